/* rtl/sna_pkg.sv */
// sna_pkg: shared types and constants of the supernet aggregator
// no dependencies
`timescale 1ns / 1ps

package sna_pkg;

  localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;
  localparam logic [4:0]  MAX_SUPER_PREFIX = 5'd31;
  localparam logic [5:0]  FULL_PREFIX      = 6'd32;
  localparam logic [1:0]  SEEN_ENOUGH      = 2'd2;
  localparam logic        STATUS_OK        = 1'b0;
  localparam logic        STATUS_TOO_FEW   = 1'b1;

  // summary of one finished run, passed from front to back
  typedef struct packed {
    logic [31:0] lowest_network;
    logic [31:0] highest_broadcast;
    logic        enough;
  } sna_run_t;

endpackage

/* rtl/sna_ifs.sv */
// sna_ifs: valid/ready channel interfaces for subnet input and supernet result
// no dependencies
`timescale 1ns / 1ps

interface sna_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] subnet_address;
  logic [5:0]  prefix_len;
  logic        last_subnet;

  modport source (output valid, output subnet_address, output prefix_len,
                  output last_subnet, input ready);
  modport sink   (input valid, input subnet_address, input prefix_len,
                  input last_subnet, output ready);
endinterface

interface sna_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] supernet_address;
  logic [4:0]  supernet_prefix;
  logic        status;

  modport source (output valid, output supernet_address, output supernet_prefix,
                  output status, input ready);
  modport sink   (input valid, input supernet_address, input supernet_prefix,
                  input status, output ready);
endinterface

/* rtl/sna_front.sv */
// sna_front: masks each subnet, tracks lowest network, highest broadcast and count
// depends on sna_pkg; pushes one run summary per last subnet
`timescale 1ns / 1ps

module sna_front
  import sna_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_subnet_address,
  input  logic [5:0]  in_prefix_len,
  input  logic        in_last_subnet,
  output logic        push,
  output sna_run_t    push_data,
  input  logic        q_full
);

  logic [31:0] low_r, low_nxt;
  logic [31:0] high_r, high_nxt;
  logic [1:0]  seen_r, seen_nxt;

  logic [5:0]  len_c;
  logic [31:0] host_mask;
  logic [31:0] net;
  logic [31:0] bcast;
  logic [31:0] low_upd;
  logic [31:0] high_upd;
  logic [1:0]  seen_upd;
  logic        xfer;

  assign in_ready = rst_n && !q_full;
  assign xfer     = in_valid && in_ready;

  always_comb begin
    len_c     = (in_prefix_len > FULL_PREFIX) ? FULL_PREFIX : in_prefix_len;
    host_mask = ALL_ONES >> len_c;
    net       = in_subnet_address & ~host_mask;
    bcast     = net | host_mask;
    low_upd   = (net < low_r) ? net : low_r;
    high_upd  = (bcast > high_r) ? bcast : high_r;
    seen_upd  = (seen_r == SEEN_ENOUGH) ? seen_r : seen_r + 2'd1;
  end

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    seen_nxt = seen_r;
    if (xfer) begin
      if (in_last_subnet) begin
        low_nxt  = ALL_ONES;
        high_nxt = '0;
        seen_nxt = '0;
      end else begin
        low_nxt  = low_upd;
        high_nxt = high_upd;
        seen_nxt = seen_upd;
      end
    end
  end

  assign push                        = xfer && in_last_subnet;
  assign push_data.lowest_network    = low_upd;
  assign push_data.highest_broadcast = high_upd;
  assign push_data.enough            = (seen_upd == SEEN_ENOUGH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= ALL_ONES;
      high_r <= '0;
      seen_r <= '0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

/* rtl/sna_queue.sv */
// sna_queue: two-entry queue of run summaries between front and back
// depends on sna_pkg
`timescale 1ns / 1ps

module sna_queue
  import sna_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sna_run_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output sna_run_t q_data,
  output logic [1:0] level
);

  sna_run_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rd_ptr_r];
  assign level   = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/sna_back.sv */
// sna_back: finds the covering supernet of a run summary and registers the result
// depends on sna_pkg
`timescale 1ns / 1ps

module sna_back
  import sna_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  sna_run_t    q_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_supernet_address,
  output logic [4:0]  out_supernet_prefix,
  output logic        out_status
);

  logic        valid_r, valid_nxt;
  logic [31:0] addr_r;
  logic [4:0]  prefix_r;
  logic        status_r;

  logic [31:0] diff;
  logic [4:0]  common;
  logic [31:0] super_addr;

  // longest common leading run of lowest network and highest broadcast, capped at /31
  always_comb begin
    diff   = q_data.lowest_network ^ q_data.highest_broadcast;
    common = MAX_SUPER_PREFIX;
    for (int i = 0; i < 32; i++) begin
      if (diff[i]) begin
        common = MAX_SUPER_PREFIX - 5'(i);
      end
    end
    super_addr = q_data.lowest_network & ~(ALL_ONES >> common);
  end

  assign pop       = q_valid && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_data.enough) begin
        addr_r   <= super_addr;
        prefix_r <= common;
        status_r <= STATUS_OK;
      end else begin
        addr_r   <= '0;
        prefix_r <= '0;
        status_r <= STATUS_TOO_FEW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid            = valid_r;
  assign out_supernet_address = addr_r;
  assign out_supernet_prefix  = prefix_r;
  assign out_status           = status_r;

endmodule

/* rtl/supernet_aggregator_top.sv */
// supernet_aggregator_top: smallest covering ipv4 supernet of a run of subnets
// depends on sna_pkg, sna_ifs, sna_front, sna_queue, sna_back
//
// in_if carries one subnet per transfer: address, prefix length (above 32
// counts as 32) and a last flag. out_if carries one result per run, on
// the transfer of the last subnet: supernet address, prefix 0..31 and
// status (1 when the run held fewer than two subnets, fields then zero).
// one subnet is taken every cycle while the queue is not full; the front
// updates its running minimum and maximum in the cycle of the transfer and
// hands a run summary to a two-entry queue. the back takes one summary a
// cycle while its output register is empty or being taken, resolves the
// prefix with a 32-bit leading-match encoder and registers the result; a
// summary passes the queue and the output register before out_if.valid
// rises. in_if.ready drops, reset apart, only while the queue is full,
// which needs out_if.ready low with results pending. a stalled result
// holds until taken. reset (rst_n low, synchronous) clears the running
// state, queue and out_if.valid; in_if.ready stays low while rst_n is low.
`timescale 1ns / 1ps

module supernet_aggregator_top
  import sna_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  sna_in_if.sink  in_if,
  sna_out_if.source out_if
);

  logic       push;
  sna_run_t   push_data;
  logic       q_full;
  logic       pop;
  logic       q_valid;
  sna_run_t   q_data;
  logic [1:0] q_level;

  sna_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_if.valid),
    .in_ready          (in_if.ready),
    .in_subnet_address (in_if.subnet_address),
    .in_prefix_len     (in_if.prefix_len),
    .in_last_subnet    (in_if.last_subnet),
    .push              (push),
    .push_data         (push_data),
    .q_full            (q_full)
  );

  sna_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .level     (q_level)
  );

  sna_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_data               (q_data),
    .pop                  (pop),
    .out_valid            (out_if.valid),
    .out_ready            (out_if.ready),
    .out_supernet_address (out_if.supernet_address),
    .out_supernet_prefix  (out_if.supernet_prefix),
    .out_status           (out_if.status)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level != 2'd3)
    else $error("queue level out of range");

  a_last_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready && in_if.last_subnet |=> q_level != 2'd0 || out_if.valid)
    else $error("last subnet produced no pending result");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.status == STATUS_TOO_FEW |->
      out_if.supernet_address == '0 && out_if.supernet_prefix == '0)
    else $error("error result with nonzero fields");

  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.status == STATUS_OK |->
      (out_if.supernet_address & (ALL_ONES >> out_if.supernet_prefix)) == '0)
    else $error("supernet address not aligned to its prefix");

endmodule
